// ===== src/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier package
// Shared types and constants: event codes, register indexes, the tracked
// button state and the reset values of the timing registers.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  // Classification result of one sample
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2,
    EV_RESET = 2'd3
  } bpc_event_e;

  // Timing register indexes; the fourth code writes nothing
  typedef enum logic [IdxW-1:0] {
    CFG_DEBOUNCE    = 2'd0,
    CFG_LONG_PRESS  = 2'd1,
    CFG_RESET_PRESS = 2'd2
  } bpc_cfg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst   = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst  = 16'd1000;
  localparam logic [CfgW-1:0] ResetPressRst = 16'd5000;

  // Debounced button state carried from sample to sample
  typedef struct packed {
    logic             acc_level;    // 1 released, 0 pressed
    logic [TimeW-1:0] last_change;
    logic [TimeW-1:0] press_start;
    logic             reset_fired;
  } bpc_state_t;

  // Timing thresholds
  typedef struct packed {
    logic [CfgW-1:0] debounce;
    logic [CfgW-1:0] long_thr;
    logic [CfgW-1:0] reset_thr;
  } bpc_cfg_t;

endpackage

// ===== src/bpc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier: sample evaluation
// Debounces one level sample against the current state and returns the
// next state together with the click, long press or reset press event.
// ----------------------------------------------------------------------------
module bpc_classify (
  input  bpc_pkg::bpc_state_t           state_i,
  input  bpc_pkg::bpc_cfg_t             cfg_i,
  input  logic                          level_i,
  input  logic [bpc_pkg::TimeW-1:0]     now_ms_i,
  output bpc_pkg::bpc_state_t           state_o,
  output bpc_pkg::bpc_event_e           event_o
);

  logic [bpc_pkg::TimeW-1:0] since_change;
  logic [bpc_pkg::TimeW-1:0] held;
  logic                      change_ok;
  logic                      is_long;
  logic                      is_reset_hold;

  // Elapsed times, wrapping modulo 2^32
  assign since_change = now_ms_i - state_i.last_change;
  assign held         = now_ms_i - state_i.press_start;

  assign change_ok = (level_i != state_i.acc_level) &&
                     (since_change > {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg_i.debounce});
  assign is_long   = held > {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg_i.long_thr};
  assign is_reset_hold =
      held > {{(bpc_pkg::TimeW-bpc_pkg::CfgW){1'b0}}, cfg_i.reset_thr};

  // Accept a change, or check the raw level for a reset press
  always_comb begin
    state_o = state_i;
    event_o = bpc_pkg::EV_NONE;
    if (change_ok) begin
      state_o.last_change = now_ms_i;
      state_o.acc_level   = level_i;
      if (!level_i) begin
        state_o.press_start = now_ms_i;
        state_o.reset_fired = 1'b0;
      end else if (!state_i.reset_fired) begin
        event_o = is_long ? bpc_pkg::EV_LONG : bpc_pkg::EV_CLICK;
      end
    end else if (!level_i && is_reset_hold && !state_i.reset_fired) begin
      event_o             = bpc_pkg::EV_RESET;
      state_o.reset_fired = 1'b1;
    end
  end

endmodule

// ===== src/button_press_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier
// Debounced push-button detector giving click, long press and reset press.
// ----------------------------------------------------------------------------
// Every accepted sample request gives exactly one event request (none, click,
// long press or reset press). A sample is held in an input register, then
// evaluated combinationally against the debounced state and written to the
// event register, so a new sample is taken every clock while the event
// consumer keeps up. The button state updates only when a sample moves
// into the event register, so a stalled event consumer holds back samples
// without losing any. Timing registers are written through the configuration
// channel, which is always ready; write them only while no sample is in
// flight.
module button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          level_i,
  input  logic [bpc_pkg::TimeW-1:0]     now_ms_i,
  // event channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    event_res_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpc_pkg::IdxW-1:0]      cfg_index_i,
  input  logic [bpc_pkg::CfgW-1:0]      cfg_data_i
);

  bpc_pkg::bpc_cfg_t    cfg_q;
  bpc_pkg::bpc_state_t  st_q, st_d;
  bpc_pkg::bpc_event_e  ev_d, ev_q;

  logic                      smp_vld_q;
  logic                      smp_level_q;
  logic [bpc_pkg::TimeW-1:0] smp_now_q;
  logic                      out_vld_q;
  logic                      advance;

  // Move a sample to the event register when that register is free
  assign advance     = smp_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !smp_vld_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign event_res_o = ev_q;

  // Write timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce  <= bpc_pkg::DebounceRst;
      cfg_q.long_thr  <= bpc_pkg::LongPressRst;
      cfg_q.reset_thr <= bpc_pkg::ResetPressRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bpc_pkg::CFG_DEBOUNCE:    cfg_q.debounce  <= cfg_data_i;
        bpc_pkg::CFG_LONG_PRESS:  cfg_q.long_thr  <= cfg_data_i;
        bpc_pkg::CFG_RESET_PRESS: cfg_q.reset_thr <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the incoming sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      smp_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_level_q <= level_i;
      smp_now_q   <= now_ms_i;
    end
  end

  bpc_classify u_classify (
    .state_i  (st_q),
    .cfg_i    (cfg_q),
    .level_i  (smp_level_q),
    .now_ms_i (smp_now_q),
    .state_o  (st_d),
    .event_o  (ev_d)
  );

  // Advance button state and event register together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.acc_level   <= 1'b1;
      st_q.last_change <= '0;
      st_q.press_start <= '0;
      st_q.reset_fired <= 1'b0;
      out_vld_q        <= 1'b0;
      ev_q             <= bpc_pkg::EV_NONE;
    end else begin
      if (advance) begin
        st_q <= st_d;
        ev_q <= ev_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // A shown reset press always has its flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ev_q == bpc_pkg::EV_RESET) |-> st_q.reset_fired)
    else $error("reset press shown without reset flag");

  // A click or long press leaves the button released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (ev_d == bpc_pkg::EV_CLICK || ev_d == bpc_pkg::EV_LONG))
    |=> st_q.acc_level)
    else $error("release event without released state");

  // Samples stall only behind a stalled event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_vld_q && !out_ready_i && smp_vld_q))
    else $error("sample channel stalled without cause");

endmodule

// ===== tb/button_press_classifier_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Drives pin samples and timing register writes into the classifier. An
// in-bench tracker predicts the event for every sample request and checks
// each event request in order. Directed cases come first, then random press
// sequences with bounce and noise under several timing settings.
// ----------------------------------------------------------------------------
module button_press_classifier_test;

  localparam logic [bpc_pkg::IdxW-1:0] CfgIdxSpare = 2'd3;  // decodes to no register
  localparam int unsigned     CycleLimit   = 400_000;
  localparam int unsigned     PhaseItems   = 185;
  localparam int unsigned     NumPhases    = 10;
  localparam int unsigned     ReportLimit  = 10;

  // Debounce tracker: predicts the event of each sample and holds the
  // events still due from the block.
  class event_ledger;
    logic [bpc_pkg::CfgW-1:0]  debounce_ms;
    logic [bpc_pkg::CfgW-1:0]  long_press_ms;
    logic [bpc_pkg::CfgW-1:0]  reset_press_ms;
    logic                      acc_level;
    logic [bpc_pkg::TimeW-1:0] last_change;
    logic [bpc_pkg::TimeW-1:0] press_start;
    logic                      reset_fired;
    bpc_pkg::bpc_event_e       due_events[$];
    int unsigned               errors;

    function new();
      debounce_ms    = bpc_pkg::DebounceRst;
      long_press_ms  = bpc_pkg::LongPressRst;
      reset_press_ms = bpc_pkg::ResetPressRst;
      acc_level      = 1'b1;
      last_change    = '0;
      press_start    = '0;
      reset_fired    = 1'b0;
      errors         = 0;
    endfunction

    function void take_write(input logic [bpc_pkg::IdxW-1:0] idx,
                             input logic [bpc_pkg::CfgW-1:0] val);
      case (idx)
        bpc_pkg::CFG_DEBOUNCE:    debounce_ms    = val;
        bpc_pkg::CFG_LONG_PRESS:  long_press_ms  = val;
        bpc_pkg::CFG_RESET_PRESS: reset_press_ms = val;
        default: ;
      endcase
    endfunction

    // Advance the button state by one sample and queue its event
    function void take_sample(input logic lvl, input logic [bpc_pkg::TimeW-1:0] t_ms);
      logic [bpc_pkg::TimeW-1:0] since;
      logic [bpc_pkg::TimeW-1:0] held;
      bpc_pkg::bpc_event_e       ev;
      since = t_ms - last_change;
      held  = t_ms - press_start;
      ev    = bpc_pkg::EV_NONE;
      if (lvl != acc_level && since > debounce_ms) begin
        last_change = t_ms;
        acc_level   = lvl;
        if (!lvl) begin
          press_start = t_ms;
          reset_fired = 1'b0;
        end else if (!reset_fired) begin
          ev = (held > long_press_ms) ? bpc_pkg::EV_LONG : bpc_pkg::EV_CLICK;
        end
      end else if (!lvl && held > reset_press_ms && !reset_fired) begin
        ev          = bpc_pkg::EV_RESET;
        reset_fired = 1'b1;
      end
      due_events.push_back(ev);
    endfunction

    function void note_error(input string msg);
      errors++;
      if (errors <= ReportLimit) $display("mismatch: %s", msg);
    endfunction

    function void check_event(input logic [1:0] got);
      bpc_pkg::bpc_event_e want;
      if (due_events.size() == 0) begin
        note_error($sformatf("event %0d with no sample pending", got));
        return;
      end
      want = due_events.pop_front();
      if (got !== want)
        note_error($sformatf("expected %s (%0d), got %0d", want.name(), want, got));
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        level_i;
  logic [bpc_pkg::TimeW-1:0]   now_ms_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [1:0]                  event_res_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [bpc_pkg::IdxW-1:0]    cfg_index_i;
  logic [bpc_pkg::CfgW-1:0]    cfg_data_i;

  event_ledger ledger = new();
  int unsigned sent;
  int unsigned tx_mode;
  int unsigned rx_mode;
  int unsigned cycle_count;

  button_press_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .level_i     (level_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check every event request against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_event(event_res_o);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("button_press_classifier_test: done, errors");
      $finish;
    end
  end

  // Idle length per request: none, anywhere in range, or rare gaps
  function automatic int unsigned draw_gap(input int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  // Event consumer: drop ready for a drawn stall, then hold it until a request
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ready_i = 1'b0;
    taken       = 0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) rx_mode = $urandom_range(0, 2);
      stall = draw_gap(rx_mode);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  // Offer one sample; valid stays high after acceptance until the next
  // request or a settle
  task automatic send_sample(input logic lvl, input logic [bpc_pkg::TimeW-1:0] t_ms);
    int unsigned gap;
    if (sent % 40 == 0) tx_mode = $urandom_range(0, 2);
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    now_ms_i   <= t_ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.take_sample(lvl, t_ms);
    sent++;
  endtask

  // Drop valid and wait until every event has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.due_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bpc_pkg::IdxW-1:0] idx,
                           input logic [bpc_pkg::CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.take_write(idx, val);
  endtask

  // Program all timing registers, plus a write to the unused index
  task automatic program_regs(input logic [bpc_pkg::CfgW-1:0] deb,
                              input logic [bpc_pkg::CfgW-1:0] lp,
                              input logic [bpc_pkg::CfgW-1:0] rp);
    write_reg(bpc_pkg::CFG_DEBOUNCE, deb);
    write_reg(bpc_pkg::CFG_LONG_PRESS, lp);
    write_reg(bpc_pkg::CFG_RESET_PRESS, rp);
    write_reg(CfgIdxSpare, 16'($urandom()));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold length aimed at the thresholds and around them
  function automatic int unsigned pick_hold();
    int unsigned lp;
    int unsigned rp;
    lp = 32'(ledger.long_press_ms);
    rp = 32'(ledger.reset_press_ms);
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, lp);
      1:       return lp;
      2:       return lp + 1;
      3:       return $urandom_range(lp + 1, rp + 1);
      4:       return rp;
      5:       return rp + 1;
      6:       return $urandom_range(rp + 2, rp + rp / 2 + 3);
      default: return 32'(ledger.debounce_ms) + $urandom_range(0, 1);
    endcase
  endfunction

  // One press and release with bounce around both edges
  task automatic press_cycle();
    repeat ($urandom_range(0, 3))
      send_sample(1'($urandom_range(0, 1)),
                  ledger.last_change + $urandom_range(0, ledger.debounce_ms));
    send_sample(1'b0, ledger.last_change + ledger.debounce_ms + 1 + $urandom_range(0, 2));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0)
        send_sample(1'b1, ledger.last_change + $urandom_range(0, ledger.debounce_ms));
      else
        send_sample(1'b0, ledger.press_start + pick_hold());
    end
    send_sample(1'b1, ledger.press_start + pick_hold());
    repeat ($urandom_range(0, 2))
      send_sample(1'($urandom_range(0, 1)),
                  ledger.last_change + $urandom_range(0, ledger.debounce_ms));
  endtask

  // Stray samples: any time, near the wrap, near the last change or a press hold
  task automatic noise_sample();
    case ($urandom_range(0, 3))
      0: send_sample(1'($urandom_range(0, 1)), $urandom());
      1: send_sample(1'($urandom_range(0, 1)),
                     32'hFFFF_FFFF - $urandom_range(0, 3 * ledger.debounce_ms + 2));
      2: send_sample(1'($urandom_range(0, 1)),
                     ledger.last_change + $urandom_range(0, 2 * ledger.debounce_ms + 2));
      default: send_sample(1'($urandom_range(0, 1)), ledger.press_start + pick_hold());
    endcase
  endtask

  initial begin
    int unsigned quota;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    level_i     = 1'b1;
    now_ms_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bpc_pkg::CFG_DEBOUNCE;
    cfg_data_i  = '0;
    sent        = 0;
    tx_mode     = 0;
    rx_mode     = 0;
    cycle_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset press before any press: long debounce keeps the pin change out
    program_regs(16'hFFFF, bpc_pkg::LongPressRst, 16'd100);
    send_sample(1'b0, 32'd200);
    send_sample(1'b0, 32'd300);      // already fired, stays quiet
    send_sample(1'b1, 32'd400);      // release inside the debounce window
    settle();

    program_regs(bpc_pkg::DebounceRst, bpc_pkg::LongPressRst, bpc_pkg::ResetPressRst);
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'd30);       // press inside the debounce window
    send_sample(1'b0, 32'd51);       // accepted press
    send_sample(1'b1, 32'd80);       // release bounce
    send_sample(1'b1, 32'd400);      // click
    send_sample(1'b0, 32'd1000);
    send_sample(1'b1, 32'd2001);     // just over long press
    send_sample(1'b0, 32'd3000);
    send_sample(1'b1, 32'd4000);     // exactly long press: still a click
    send_sample(1'b0, 32'd5000);
    send_sample(1'b0, 32'd10000);    // exactly reset press: nothing yet
    send_sample(1'b0, 32'd10001);    // reset press
    send_sample(1'b1, 32'd10100);    // release after reset press: no event
    send_sample(1'b0, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_0010); // bounce across the wrap
    send_sample(1'b1, 32'h0000_0100); // click across the wrap
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0033);
    settle();

    // Random press sequences under a run of timing settings
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       program_regs(16'd0, 16'd0, 16'd0);
        1:       program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2:       program_regs(bpc_pkg::DebounceRst, bpc_pkg::LongPressRst,
                              bpc_pkg::ResetPressRst);
        9:       program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()));
        default: program_regs(16'($urandom_range(0, 30)), 16'($urandom_range(0, 300)),
                              16'($urandom_range(0, 800)));
      endcase
      quota = sent + PhaseItems;
      while (sent < quota) begin
        if ($urandom_range(0, 4) == 0) noise_sample();
        else press_cycle();
      end
      settle();
    end

    if (ledger.errors == 0 && ledger.due_events.size() == 0)
      $display("button_press_classifier_test: done, clean");
    else
      $display("button_press_classifier_test: done, errors");
    $finish;
  end

endmodule

// ===== button_press_classifier.f =====
src/bpc_pkg.sv
src/bpc_classify.sv
src/button_press_classifier.sv
tb/button_press_classifier_test.sv
